// ----- rtl/swm_pkg.sv -----
// Shared constants, command/status types and helpers for the sliding window median filter.
// No dependencies; every other file of the block but swm_ram imports this package.
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int RES_W      = SAMPLE_W + 1;
  localparam int WSIZE_W    = 7;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // take a new request
    logic start;    // ring write (not full) or ring read of the oldest sample
    logic old;      // capture the leaving sample, set up the merge pass
    logic pass;     // stream the sorted store into the other bank
    logic flush;    // write the last pending entry
    logic commit;   // finish the request, load the result if there is one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             pass_done;
    logic             has_result;
    logic             out_busy;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] fill_new;
    logic [CNT_W-1:0] wsize;
    logic [CNT_W-1:0] wr_ptr;
  } sts_t;

  // Effective window size: zero counts as one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_size(input logic [WSIZE_W-1:0] w);
    logic [CNT_W-1:0] k;
    if (w == '0) begin
      k = CNT_W'(1);
    end else if (32'(w) > WINDOW_MAX) begin
      k = CNT_W'(WINDOW_MAX);
    end else begin
      k = CNT_W'(w);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/swm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the arrival ring and both sorted-store banks.
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/swm_ctrl.sv -----
// Controller state machine of the sliding window median filter.
// Depends on swm_pkg for the command and status types.
`default_nettype none

module swm_ctrl
  import swm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_OLD   = 3'd2;
  localparam logic [2:0] ST_PASS  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  // Only an idle controller takes a request.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_OLD;
      end
      ST_OLD: begin
        cmd_o.old = 1'b1;
        state_d   = ST_PASS;
      end
      ST_PASS: begin
        cmd_o.pass = 1'b1;
        if (sts_i.pass_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // Hold while a result is due and the output register is still occupied.
        if (!(sts_i.has_result && sts_i.out_busy)) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/swm_dpath.sv -----
// Datapath of the sliding window median filter: arrival ring, two sorted-store banks,
// merge pass logic, window counters and the output register. Depends on swm_pkg, swm_ram.
`default_nettype none

module swm_dpath
  import swm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                restart_i,
  input  wire logic                cfg_we_i,
  input  wire logic [WSIZE_W-1:0]  cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [RES_W-1:0]  median_doubled_o
);

  // Control registers.
  logic [WSIZE_W-1:0] wsize_q;
  logic [CNT_W-1:0]   fill_q;
  logic [IDX_W-1:0]   slot_q;
  logic               bank_q;
  logic               out_valid_q;
  logic [CNT_W-1:0]   rd_idx_q;
  logic               rd_vld_q;
  logic [CNT_W-1:0]   wr_ptr_q;
  logic               rem_q;
  logic               ins_q;
  logic               carry_vld_q;

  // Payload registers.
  logic signed [SAMPLE_W-1:0] s_q;
  logic signed [SAMPLE_W-1:0] old_q;
  logic signed [SAMPLE_W-1:0] carry_q;
  logic signed [SAMPLE_W-1:0] med_hi_q;
  logic signed [SAMPLE_W-1:0] med_lo_q;
  logic signed [RES_W-1:0]    res_q;

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] hi_idx, lo_idx;
  logic             full;
  logic [CNT_W-1:0] fill_new;
  logic             has_result;
  logic [CNT_W-1:0] slot_inc;

  assign k          = eff_size(wsize_q);
  assign hi_idx     = k >> 1;
  assign lo_idx     = (k - CNT_W'(1)) >> 1;
  assign full       = (fill_q >= k);
  assign fill_new   = full ? fill_q : fill_q + CNT_W'(1);
  assign has_result = (fill_new == k);
  assign slot_inc   = {1'b0, slot_q} + CNT_W'(1);

  // Arrival ring: written at the next free slot while filling, else at the oldest slot.
  logic                ring_we;
  logic [IDX_W-1:0]    ring_waddr;
  logic [SAMPLE_W-1:0] ring_rdata;

  assign ring_we    = (cmd_i.start && !full) || (cmd_i.old && full);
  assign ring_waddr = full ? slot_q : fill_q[IDX_W-1:0];

  swm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (s_q),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  // Sorted store banks: read one bank, write the merged result into the other.
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] wr_val;
  logic [SAMPLE_W-1:0]        rdata_a, rdata_b;
  logic signed [SAMPLE_W-1:0] x;

  swm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (wr_en && bank_q),
    .waddr_i (wr_ptr_q[IDX_W-1:0]),
    .wdata_i (wr_val),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata_a)
  );

  swm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (wr_en && !bank_q),
    .waddr_i (wr_ptr_q[IDX_W-1:0]),
    .wdata_i (wr_val),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata_b)
  );

  assign x = bank_q ? $signed(rdata_b) : $signed(rdata_a);

  // Merge step: drop the leaving sample once, place the new sample before the
  // first larger entry. A carry register absorbs the cycle that yields two entries.
  logic rd_issue;
  logic skip;
  logic ins_now;
  logic carry_vld_d;
  logic signed [SAMPLE_W-1:0] carry_d;

  assign rd_issue = cmd_i.pass && (rd_idx_q < fill_q);
  assign skip     = rem_q && (x == old_q);
  assign ins_now  = !skip && ins_q && (x > s_q);

  always_comb begin
    wr_en       = 1'b0;
    wr_val      = x;
    carry_vld_d = carry_vld_q;
    carry_d     = carry_q;
    if (cmd_i.pass && rd_vld_q) begin
      if (carry_vld_q) begin
        wr_en       = 1'b1;
        wr_val      = carry_q;
        carry_vld_d = !skip;
        carry_d     = x;
      end else if (ins_now) begin
        wr_en       = 1'b1;
        wr_val      = s_q;
        carry_vld_d = 1'b1;
        carry_d     = x;
      end else if (!skip) begin
        wr_en  = 1'b1;
        wr_val = x;
      end
    end else if (cmd_i.flush) begin
      if (carry_vld_q) begin
        wr_en       = 1'b1;
        wr_val      = carry_q;
        carry_vld_d = 1'b0;
      end else if (ins_q) begin
        wr_en  = 1'b1;
        wr_val = s_q;
      end
    end
  end

  // Control state of the window and the merge pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= WSIZE_RESET;
      fill_q      <= '0;
      slot_q      <= '0;
      bank_q      <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      wr_ptr_q    <= '0;
      rem_q       <= 1'b0;
      ins_q       <= 1'b0;
      carry_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wsize_q <= cfg_data_i;
        fill_q  <= '0;
        slot_q  <= '0;
      end else if (cmd_i.accept && restart_i) begin
        fill_q <= '0;
        slot_q <= '0;
      end else if (cmd_i.old && full) begin
        slot_q <= (slot_inc == k) ? '0 : slot_inc[IDX_W-1:0];
      end else if (cmd_i.commit) begin
        fill_q <= fill_new;
      end

      if (cmd_i.commit) begin
        bank_q <= !bank_q;
      end

      if (cmd_i.old) begin
        rd_idx_q    <= '0;
        rd_vld_q    <= 1'b0;
        wr_ptr_q    <= '0;
        rem_q       <= full;
        ins_q       <= 1'b1;
        carry_vld_q <= 1'b0;
      end else begin
        rd_vld_q    <= rd_issue;
        carry_vld_q <= carry_vld_d;
        if (rd_issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (wr_en) begin
          wr_ptr_q <= wr_ptr_q + CNT_W'(1);
        end
        if (cmd_i.pass && rd_vld_q && skip) begin
          rem_q <= 1'b0;
        end
        if ((cmd_i.pass && rd_vld_q && ins_now) || (cmd_i.flush && wr_en)) begin
          ins_q <= 1'b0;
        end
      end
    end
  end

  // Payload capture: request sample, leaving sample, carry, the two middle entries and the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q <= sample_i;
    end
    if (cmd_i.old) begin
      old_q <= $signed(ring_rdata);
    end
    carry_q <= carry_d;
    if (wr_en && (wr_ptr_q == hi_idx)) begin
      med_hi_q <= wr_val;
    end
    if (wr_en && (wr_ptr_q == lo_idx)) begin
      med_lo_q <= wr_val;
    end
    if (cmd_i.commit && has_result) begin
      res_q <= RES_W'(med_hi_q) + RES_W'(med_lo_q);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = res_q;

  // Status toward the controller.
  assign sts_o.pass_done  = (rd_idx_q == fill_q) && !rd_vld_q;
  assign sts_o.has_result = has_result;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;
  assign sts_o.fill       = fill_q;
  assign sts_o.fill_new   = fill_new;
  assign sts_o.wsize      = k;
  assign sts_o.wr_ptr     = wr_ptr_q;

endmodule

`default_nettype wire

// ----- rtl/sliding_window_median.sv -----
// Sliding window median filter, top level. A request keeps the input stalled after acceptance
// until its merge pass and commit are done; the merge pass reads the sorted store one entry a
// cycle over the n samples held before it, at most the window size. The result is registered
// when the request commits; a new request is taken only after the last one is committed,
// and a new result that finds the output register still stalled waits for it to leave.
// Reset empties the window, clears the ring pointer and sets the window size to 3; memories keep.
`default_nettype none

module sliding_window_median
  import swm_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       restart_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [RES_W-1:0]         median_doubled_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [WSIZE_W-1:0]         cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swm_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (sample_i),
    .restart_i        (restart_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .median_doubled_o (median_doubled_o)
  );

  // The window never holds more samples than its size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.fill <= sts.wsize)
    else $error("window fill exceeds window size");

  // At the end of a request the merge pass has written exactly the new window.
  a_merge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (sts.wr_ptr == sts.fill_new))
    else $error("merge pass wrote a wrong number of entries");

  // A result appears only right after a request that completes a full window.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit && sts.has_result))
    else $error("result appeared without a completed request");

endmodule

`default_nettype wire

// ----- bench/tb_sliding_window_median.sv -----
// Self-checking testbench for the sliding window median filter: a queued request driver,
// a monitor with its own median predictor, random idling on both channels and a watchdog.
// Depends on swm_pkg and the sliding_window_median top level only.
`default_nettype none

module tb_sliding_window_median
  import swm_pkg::*;
();

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 1530;
  localparam int CALM_TAIL      = 150;
  // Settling time before a size write and at the end of the run; leave a generous margin.
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [1:0] {REQ_SAMPLE, REQ_CONFIG, REQ_PAUSE} req_kind_e;

  typedef struct {
    req_kind_e                   kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        restart;
    logic [WSIZE_W-1:0]          wsize;
  } request_t;

  // DUT ports.
  logic                        clk_i      = 1'b0;
  logic                        rst_ni     = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  sample_i   = '0;
  logic                        restart_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [RES_W-1:0]     median_doubled_o;
  logic                        cfg_we_i   = 1'b0;
  logic [WSIZE_W-1:0]          cfg_data_i = '0;

  // Stimulus and scoreboard state.
  request_t                    request_q[$];
  logic signed [RES_W-1:0]     median_q[$];
  logic signed [RES_W-1:0]     want_median;
  int                          outstanding = 0;
  logic                        stim_done   = 1'b0;
  logic                        calm        = 1'b0;
  int                          errors      = 0;
  int                          gap_left;
  int                          settle_cnt;
  int                          stall_left;
  int                          lull_left;
  int                          idle_cycles = 0;

  // Predictor state: arrival ring, sorted window, fill level, oldest slot, window size.
  logic signed [SAMPLE_W-1:0]  ring_mem   [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0]  sorted_mem [WINDOW_MAX];
  int unsigned                 held_cnt;
  int unsigned                 oldest_idx;
  logic [WSIZE_W-1:0]          win_reg;

  sliding_window_median dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .median_doubled_o (median_doubled_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Update the window with one sample and queue twice the median once the window is full.
  function automatic void predict_median(input logic signed [SAMPLE_W-1:0] s,
                                         input logic rs);
    int unsigned                k;
    int unsigned                slot;
    int unsigned                i;
    logic signed [SAMPLE_W-1:0] leaving;
    logic signed [RES_W-1:0]    lo;
    logic signed [RES_W-1:0]    hi;
    k = (win_reg == '0) ? 1 : ((int'(win_reg) > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg));
    if (rs) begin
      held_cnt   = 0;
      oldest_idx = 0;
    end
    if (held_cnt >= k) begin
      // Window full: the oldest sample leaves both stores first.
      slot    = oldest_idx % k;
      leaving = ring_mem[slot];
      i = 0;
      while (i < held_cnt && sorted_mem[i] != leaving) i++;
      if (i < held_cnt) begin
        for (; i + 1 < held_cnt; i++) sorted_mem[i] = sorted_mem[i + 1];
        held_cnt--;
      end
      ring_mem[slot] = s;
      oldest_idx     = (slot + 1) % k;
    end else begin
      ring_mem[held_cnt] = s;
    end
    // Insertion into the ascending store.
    i = held_cnt;
    while (i > 0 && sorted_mem[i - 1] > s) begin
      sorted_mem[i] = sorted_mem[i - 1];
      i--;
    end
    sorted_mem[i] = s;
    held_cnt++;
    if (held_cnt >= k) begin
      lo = RES_W'(sorted_mem[(k - 1) / 2]);
      hi = RES_W'(sorted_mem[k / 2]);
      median_q.insert(median_q.size(), lo + hi);
    end
  endfunction

  function automatic void push_sample(input logic signed [SAMPLE_W-1:0] s, input logic rs);
    request_t r;
    r.kind    = REQ_SAMPLE;
    r.sample  = s;
    r.restart = rs;
    r.wsize   = '0;
    request_q.insert(request_q.size(), r);
  endfunction

  function automatic void push_config(input logic [WSIZE_W-1:0] w);
    request_t r;
    r.kind    = REQ_CONFIG;
    r.sample  = '0;
    r.restart = 1'b0;
    r.wsize   = w;
    request_q.insert(request_q.size(), r);
  endfunction

  // Request driver: holds the payload while stalled, inserts gaps, and writes the
  // window size only after every expected result has come and the block has settled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      restart_i  <= 1'b0;
      cfg_we_i   <= 1'b0;
      cfg_data_i <= '0;
      stim_done  <= 1'b0;
      calm       <= 1'b0;
      gap_left   = 0;
      settle_cnt = 0;
    end else begin
      calm <= (request_q.size() < CALM_TAIL);
      if (cfg_we_i) begin
        cfg_we_i <= 1'b0;
      end
      if (in_valid_i && in_stall_o) begin
        // Stalled: the request stays on the port unchanged.
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (request_q.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done  <= 1'b1;
      end else if (request_q[0].kind == REQ_SAMPLE) begin
        if (!calm && $urandom_range(0, 11) == 0) begin
          in_valid_i <= 1'b0;
          gap_left   = $urandom_range(0, 9);
        end else begin
          in_valid_i <= 1'b1;
          sample_i   <= request_q[0].sample;
          restart_i  <= request_q[0].restart;
          request_q.delete(0);
        end
      end else begin
        in_valid_i <= 1'b0;
        if (outstanding != 0) begin
          settle_cnt = 0;
        end else begin
          settle_cnt++;
        end
        if (settle_cnt >= SETTLE_CYCLES) begin
          if (request_q[0].kind == REQ_CONFIG) begin
            cfg_we_i   <= 1'b1;
            cfg_data_i <= request_q[0].wsize;
          end
          request_q.delete(0);
          settle_cnt = 0;
        end
      end
    end
  end

  // Receiver stall: random bursts, separated by occasional quiet lulls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      lull_left   = 0;
    end else begin
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0 && $urandom_range(0, 3) == 0) lull_left = $urandom_range(20, 100);
      end else if (lull_left != 0) begin
        lull_left--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      out_stall_i <= (stall_left != 0) && !calm;
    end
  end

  // Monitor: checks each accepted result against the oldest expectation, then feeds
  // configuration writes and accepted requests to the predictor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding <= 0;
      held_cnt    = 0;
      oldest_idx  = 0;
      win_reg     = WSIZE_RESET;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (median_q.size() == 0) begin
          $error("median_doubled: expected none, got %0d", median_doubled_o);
          errors++;
        end else begin
          want_median = median_q.pop_front();
          if (median_doubled_o !== want_median) begin
            $error("median_doubled: expected %0d, got %0d", want_median, median_doubled_o);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        // A size write always empties the window.
        win_reg    = cfg_data_i;
        held_cnt   = 0;
        oldest_idx = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_median(sample_i, restart_i);
      end
      outstanding <= median_q.size();
    end
  end

  // Watchdog on cycles without any accepted request, result or register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_sliding_window_median: FAIL");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  int unsigned                size_list [10] = '{127, 65, 64, 4, 5, 8, 17, 32, 33, 63};
  initial begin
    int                         n;
    int                         idx;
    int                         len;
    int                         v;
    logic [WSIZE_W-1:0]         w;
    logic signed [SAMPLE_W-1:0] s;
    request_t                   hold;

    // Directed part at the reset window size of three: extremes and duplicates.
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(2, 1'b0);
    push_sample(2, 1'b0);
    push_sample(2, 1'b0);
    // Restart: the window starts over with this sample.
    push_sample(5, 1'b1);
    push_sample(7, 1'b0);
    push_sample(9, 1'b0);
    // Window of one: a result at once, also right after a restart.
    push_config(WSIZE_W'(1));
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(-1, 1'b1);
    // Even window: the two middle values are summed.
    push_config(WSIZE_W'(2));
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b1);
    push_sample(S_MIN, 1'b0);
    // A size of zero counts as one.
    push_config(WSIZE_W'(0));
    push_sample(12, 1'b0);
    push_sample(3, 1'b1);

    // Random phases, each starting with a size write; oversized values saturate.
    n   = 0;
    idx = 0;
    while (n < RANDOM_ITEMS) begin
      if (idx < 10) begin
        w = WSIZE_W'(size_list[idx]);
      end else begin
        w = WSIZE_W'($urandom_range(0, 127));
      end
      idx++;
      push_config(w);
      len = $urandom_range(60, 140);
      if (w > 32) len += 64;
      if (len > RANDOM_ITEMS - n) len = RANDOM_ITEMS - n;
      repeat (len) begin
        case ($urandom_range(0, 7))
          0: s = $urandom_range(0, 1) ? S_MAX : S_MIN;
          1, 2, 3: begin
            v = $urandom_range(0, 8);
            s = v - 4;
          end
          default: s = $urandom;
        endcase
        push_sample(s, $urandom_range(0, 29) == 0);
        n++;
      end
      if (idx == 6) begin
        // Hold the sender until the result stream has fully drained.
        hold.kind    = REQ_PAUSE;
        hold.sample  = '0;
        hold.restart = 1'b0;
        hold.wsize   = '0;
        request_q.insert(request_q.size(), hold);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(stim_done && outstanding == 0)) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (median_q.size() != 0) begin
      $error("median_doubled: %0d expected results never arrived", median_q.size());
    end
    if (errors == 0 && median_q.size() == 0) begin
      $display("tb_sliding_window_median: PASS");
    end else begin
      $display("tb_sliding_window_median: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
